// ===== design/keyframe_time_sampler_unit_assert.svh =====
// assertion macros shared by the keyframe time sampler modules
`ifndef KEYFRAME_TIME_SAMPLER_UNIT_ASSERT_SVH
`define KEYFRAME_TIME_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define KTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication
`define KTS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== design/kts_pkg.sv =====
// shared types and constants of the keyframe time sampler
package kts_pkg;

    localparam int FRAC_BITS  = 40;
    localparam int BLEND_BITS = 17;
    localparam int DIV_STAGES = BLEND_BITS;

    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // play mode codes carried in the input tuser
    typedef enum logic [1:0] {
        MODE_CLAMP   = 2'd0,
        MODE_WRAP    = 2'd1,
        MODE_MIRROR  = 2'd2,
        MODE_UNKNOWN = 2'd3
    } t_mode;

    // result fields that ride alongside the blend divider
    typedef struct packed {
        logic [15:0]           frame_now;
        logic [15:0]           frame_next;
        logic [BLEND_BITS-1:0] blend_raw;
        logic                  use_quant;
        logic                  was_updated;
    } t_side;

endpackage

// ===== design/kts_map.sv =====
// time normalization, frame mapping and quantize product pipeline (six stages)
module kts_map import kts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_time,
    input  logic [1:0]         i_mode,
    input  logic [15:0]        i_fc,
    input  logic [31:0]        i_inv,
    input  logic [31:0]        i_dur,
    input  logic [15:0]        i_steps,
    output logic               o_valid,
    input  logic               i_ready,
    output t_side              o_side,
    output logic [16:0]        o_k,
    output logic [15:0]        o_steps
);

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_ZERO,
        CLS_END,
        CLS_RUN
    } t_cls;

    localparam int NST = 6;

    logic [NST-1:0] r_v;
    logic [NST-1:0] w_rdy;

    // stage registers
    logic [31:0] r1_mag, r1_inv;
    logic        r1_neg;
    t_mode       r1_mode;
    logic [15:0] r1_fcm1, r1_steps;
    t_cls        r1_cls;

    logic [63:0] r2_prod;
    logic        r2_neg;
    t_mode       r2_mode;
    logic [15:0] r2_fcm1, r2_steps;
    t_cls        r2_cls;

    logic [FRAC_BITS-1:0] r3_frac;
    logic                 r3_neg, r3_mir;
    t_mode                r3_mode;
    logic [15:0]          r3_fcm1, r3_steps;
    t_cls                 r3_cls;

    logic [FRAC_BITS+15:0] r4_p;
    logic                  r4_neg, r4_mir;
    t_mode                 r4_mode;
    logic [15:0]           r4_fcm1, r4_steps;
    t_cls                  r4_cls;

    logic [FRAC_BITS:0] r5_v;
    logic [15:0]        r5_now, r5_next;
    logic               r5_mir;
    logic [15:0]        r5_fcm1, r5_steps;
    t_cls               r5_cls;

    logic [FRAC_BITS+16:0] r6_vs;
    t_side                 r6_side;
    logic [15:0]           r6_steps;

    // next values
    logic [31:0]           n_mag;
    logic                  n_neg;
    t_mode                 n_mode;
    t_cls                  n1_cls;
    logic [63:0]           n_prod;
    logic [63:0]           n_prod_neg;
    logic [FRAC_BITS-1:0]  n_frac;
    t_cls                  n3_cls;
    logic [FRAC_BITS+15:0] n_p;
    logic [15:0]           n_key;
    logic [FRAC_BITS-1:0]  n_lerp;
    logic                  n_back;
    logic [FRAC_BITS:0]    n_v;
    logic [15:0]           n5_now, n5_next;
    logic [FRAC_BITS+16:0] n_vs;
    t_side                 n_side;

    // bubble-collapsing handshake: a stage loads when empty or when it drains
    assign w_rdy[NST-1] = !r_v[NST-1] || i_ready;
    for (genvar j = 0; j < NST - 1; j++) begin : g_rdy
        assign w_rdy[j] = !r_v[j] || w_rdy[j+1];
    end
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < NST; j++) begin
                if (w_rdy[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    // stage 1: magnitude and special cases
    assign n_neg  = i_time[31];
    assign n_mag  = n_neg ? (~i_time + 32'd1) : i_time;
    assign n_mode = t_mode'(i_mode);

    always_comb begin
        priority if (i_fc == 16'd0 || n_mode == MODE_UNKNOWN) begin
            n1_cls = CLS_NONE;
        end else if (i_fc == 16'd1) begin
            n1_cls = CLS_ZERO;
        end else if (n_mode == MODE_CLAMP && (n_neg || i_time == 32'sd0)) begin
            n1_cls = CLS_ZERO;
        end else if (n_mode == MODE_CLAMP && n_mag >= i_dur) begin
            n1_cls = CLS_END;
        end else begin
            n1_cls = CLS_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_mag   <= n_mag;
            r1_inv   <= i_inv;
            r1_neg   <= n_neg;
            r1_mode  <= n_mode;
            r1_fcm1  <= i_fc - 16'd1;
            r1_steps <= i_steps;
            r1_cls   <= n1_cls;
        end
    end

    // stage 2: normalized time as q24.40
    assign n_prod = r1_mag * r1_inv;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r2_prod  <= n_prod;
            r2_neg   <= r1_neg;
            r2_mode  <= r1_mode;
            r2_fcm1  <= r1_fcm1;
            r2_steps <= r1_steps;
            r2_cls   <= r1_cls;
        end
    end

    // stage 3: signed fraction, clamp overflow, mirror parity
    assign n_prod_neg = ~r2_prod + 64'd1;
    assign n_frac     = r2_neg ? n_prod_neg[FRAC_BITS-1:0] : r2_prod[FRAC_BITS-1:0];

    always_comb begin
        n3_cls = r2_cls;
        if (r2_cls == CLS_RUN && r2_mode == MODE_CLAMP && (|r2_prod[63:FRAC_BITS])) begin
            n3_cls = CLS_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r3_frac  <= n_frac;
            r3_neg   <= r2_neg;
            r3_mir   <= (r2_mode == MODE_MIRROR) && r2_prod[FRAC_BITS];
            r3_mode  <= r2_mode;
            r3_fcm1  <= r2_fcm1;
            r3_steps <= r2_steps;
            r3_cls   <= n3_cls;
        end
    end

    // stage 4: scale to frame range
    assign n_p = r3_frac * r3_fcm1;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r4_p     <= n_p;
            r4_neg   <= r3_neg;
            r4_mir   <= r3_mir;
            r4_mode  <= r3_mode;
            r4_fcm1  <= r3_fcm1;
            r4_steps <= r3_steps;
            r4_cls   <= r3_cls;
        end
    end

    // stage 5: keyframe pair and weight, reversed for negative time
    assign n_key  = r4_p[FRAC_BITS+15:FRAC_BITS];
    assign n_lerp = r4_p[FRAC_BITS-1:0];
    assign n_back = r4_neg && (r4_mode != MODE_CLAMP);
    assign n_v    = n_back ? (FRAC_ONE - {1'b0, n_lerp}) : {1'b0, n_lerp};
    assign n5_now  = n_back ? (n_key + 16'd1) : n_key;
    assign n5_next = n_back ? n_key : (n_key + 16'd1);

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r5_v     <= n_v;
            r5_now   <= n5_now;
            r5_next  <= n5_next;
            r5_mir   <= r4_mir;
            r5_fcm1  <= r4_fcm1;
            r5_steps <= r4_steps;
            r5_cls   <= r4_cls;
        end
    end

    // stage 6: quantize product, mirror reflection, case overrides
    assign n_vs = r5_v * r5_steps;

    always_comb begin
        n_side.use_quant   = (r5_cls == CLS_RUN) && (r5_steps != 16'd0);
        n_side.was_updated = (r5_cls != CLS_NONE);
        unique case (r5_cls)
            CLS_RUN: begin
                n_side.frame_now  = r5_mir ? (r5_fcm1 - r5_now) : r5_now;
                n_side.frame_next = r5_mir ? (r5_fcm1 - r5_next) : r5_next;
                n_side.blend_raw  = r5_v[FRAC_BITS:FRAC_BITS-16];
            end
            CLS_END: begin
                n_side.frame_now  = r5_fcm1;
                n_side.frame_next = r5_fcm1;
                n_side.blend_raw  = '0;
            end
            CLS_ZERO, CLS_NONE: begin
                n_side.frame_now  = '0;
                n_side.frame_next = '0;
                n_side.blend_raw  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r6_vs    <= n_vs;
            r6_side  <= n_side;
            r6_steps <= r5_steps;
        end
    end

    assign o_side  = r6_side;
    assign o_k     = r6_vs[FRAC_BITS+16:FRAC_BITS];
    assign o_steps = r6_steps;

endmodule

// ===== design/kts_div.sv =====
// pipelined restoring divider for the quantized blend, one quotient bit per stage
module kts_div import kts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [16:0]           i_k,
    input  logic [15:0]           i_d,
    input  t_side                 i_side,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [BLEND_BITS-1:0] o_quo,
    output t_side                 o_side
);

    `include "keyframe_time_sampler_unit_assert.svh"

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] r_v;
    logic [DIV_STAGES-1:0] w_rdy;
    logic [15:0]           r_rem  [DIV_STAGES];
    logic [BLEND_BITS-1:0] r_quo  [DIV_STAGES];
    logic [15:0]           r_d    [DIV_STAGES];
    t_side                 r_side [DIV_STAGES];

    logic [16:0]           w_rin  [DIV_STAGES];
    logic [BLEND_BITS-1:0] w_qin  [DIV_STAGES];
    logic [15:0]           w_din  [DIV_STAGES];
    logic                  w_vin  [DIV_STAGES];
    t_side                 w_sin  [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        logic        n_geq;
        logic [16:0] n_sub;

        // the first stage sees k itself, later ones the doubled remainder
        if (j == 0) begin : g_head
            assign w_rin[j] = i_k;
            assign w_qin[j] = '0;
            assign w_din[j] = i_d;
            assign w_vin[j] = i_valid;
            assign w_sin[j] = i_side;
        end else begin : g_body
            assign w_rin[j] = {r_rem[j-1], 1'b0};
            assign w_qin[j] = r_quo[j-1];
            assign w_din[j] = r_d[j-1];
            assign w_vin[j] = r_v[j-1];
            assign w_sin[j] = r_side[j-1];
        end

        if (j == LAST) begin : g_rlast
            assign w_rdy[j] = !r_v[j] || i_ready;
        end else begin : g_rmid
            assign w_rdy[j] = !r_v[j] || w_rdy[j+1];
        end

        assign n_geq = w_rin[j] >= {1'b0, w_din[j]};
        assign n_sub = w_rin[j] - {1'b0, w_din[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_v[j] <= w_vin[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j]) begin
                r_rem[j]  <= n_geq ? n_sub[15:0] : w_rin[j][15:0];
                r_quo[j]  <= {w_qin[j][BLEND_BITS-2:0], n_geq};
                r_d[j]    <= w_din[j];
                r_side[j] <= w_sin[j];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[LAST];
    assign o_quo   = r_quo[LAST];
    assign o_side  = r_side[LAST];

    `KTS_ASSERT_IMP(a_rem_below_div, r_v[LAST] && r_d[LAST] != 16'd0, r_rem[LAST] < r_d[LAST])
    `KTS_ASSERT_IMP(a_quo_at_most_one, r_v[LAST] && r_d[LAST] != 16'd0, o_quo <= 17'h10000)
    `KTS_ASSERT_NXT(a_tail_holds, r_v[LAST] && !i_ready, r_v[LAST] && $stable(r_quo[LAST]))

endmodule

// ===== design/keyframe_time_sampler_unit.sv =====
// an accepted input beat reaches its output beat through these registers
// (six mapping stages, seventeen divider stages, one output register)
// throughput: one beat per cycle unless m_axis_tready stalls; each stage fills a bubble while later ones stall
// the quantized blend divider retires one quotient bit per stage
// reset: i_rst_n synchronous, active low, clears every stage valid bit
// top level of the keyframe time sampler
module keyframe_time_sampler_unit import kts_pkg::*; #(
    parameter int FRAME_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // time_position, frame_count, inverse_duration,
                                        // duration_seconds, quantize_steps
    input  logic [1:0]   s_axis_tuser,  // play_mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,  // frame_now, frame_next, blend_amount, zero fill
    output logic [0:0]   m_axis_tuser   // was_updated
);

    `include "keyframe_time_sampler_unit_assert.svh"

    localparam int          FBE     = (FRAME_BITS < 16) ? FRAME_BITS : 16;
    localparam logic [15:0] FC_MASK = 16'((32'd1 << FBE) - 32'd1);

    logic                  w_map_valid, w_map_ready;
    t_side                 w_map_side;
    logic [16:0]           w_map_k;
    logic [15:0]           w_map_steps;
    logic                  w_div_valid, w_div_ready;
    logic [BLEND_BITS-1:0] w_div_quo;
    t_side                 w_div_side;
    logic                  w_out_rdy;

    logic                  r_ov;
    logic [15:0]           r_now, r_next;
    logic [BLEND_BITS-1:0] r_blend;
    logic                  r_upd;

    kts_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_time  ($signed(s_axis_tdata[31:0])),
        .i_mode  (s_axis_tuser),
        .i_fc    (s_axis_tdata[47:32] & FC_MASK),
        .i_inv   (s_axis_tdata[79:48]),
        .i_dur   (s_axis_tdata[111:80]),
        .i_steps (s_axis_tdata[127:112]),
        .o_valid (w_map_valid),
        .i_ready (w_map_ready),
        .o_side  (w_map_side),
        .o_k     (w_map_k),
        .o_steps (w_map_steps)
    );

    kts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_map_valid),
        .o_ready (w_map_ready),
        .i_k     (w_map_k),
        .i_d     (w_map_steps),
        .i_side  (w_map_side),
        .o_valid (w_div_valid),
        .i_ready (w_div_ready),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    assign w_out_rdy   = !r_ov || m_axis_tready;
    assign w_div_ready = w_out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_rdy) begin
            r_ov <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy) begin
            r_now   <= w_div_side.frame_now;
            r_next  <= w_div_side.frame_next;
            r_blend <= w_div_side.use_quant ? w_div_quo : w_div_side.blend_raw;
            r_upd   <= w_div_side.was_updated;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_blend, r_next, r_now};
    assign m_axis_tuser  = r_upd;

    `KTS_ASSERT_IMP(a_idle_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 56'd0)
    `KTS_ASSERT_IMP(a_blend_range, m_axis_tvalid, m_axis_tdata[48:32] <= 17'd65536)
    `KTS_ASSERT_IMP(a_stall_only_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule
